@@ hdl/refcounted_block_pool_lru_core_macros.svh @@
// assertion macros shared by the block pool rtl
// no dependencies; included by modules that carry checks
`ifndef REFCOUNTED_BLOCK_POOL_LRU_CORE_MACROS_SVH
`define REFCOUNTED_BLOCK_POOL_LRU_CORE_MACROS_SVH
// condition in the same cycle
`define RBPL_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("rbpl check failed");
// condition in the next cycle
`define RBPL_ASSERT_NEXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("rbpl check failed");
`endif

@@ hdl/rbpl_pkg.sv @@
// package for the block pool: sizes, codes and the per-block word
// no dependencies
package rbpl_pkg;
  localparam int POOL_BLOCKS = 256;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int REF_W      = 16;
  localparam int HASH_BITS  = 64;
  localparam int NCNT_W     = 7;
  localparam logic [NCNT_W-1:0] MAX_GRANT = 7'd64;
  localparam logic [REF_W-1:0]  REF_MAX   = 16'hFFFF;
  // link: msb set means null
  localparam logic [IDX_W:0] LINK_NULL = 9'h100;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_LOOKUP  = 2'd2;
  localparam logic [1:0] FN_PUBLISH = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXHAUST = 2'd1;
  localparam logic [1:0] ST_MISS    = 2'd2;
  localparam logic [1:0] ST_PUBL    = 2'd3;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic                 cached;
    logic                 lru;
    logic [REF_W-1:0]     refc;
  } blk_word_t;
endpackage

@@ hdl/rbpl_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rbpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end
endmodule

@@ hdl/refcounted_block_pool_lru_core.sv @@
// block pool top: free ring, per-block word memory, lru link memories
// depends on rbpl_pkg, rbpl_ram and refcounted_block_pool_lru_core_macros.svh
// release/publish read the block word, then answer; allocate evicts lru heads as needed, then grants
// lookup scans one entry a cycle from block 0, stops at the first hit (shared or revived), else miss
// one request at a time, in_tready rises with its last word; out stalls hold the pending result
// reset: synchronous active-low, then a clearing pass over all 256 blocks with in_tready low
`include "refcounted_block_pool_lru_core_macros.svh"
module refcounted_block_pool_lru_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // alloc_count[6:0], block_index[14:7], content_hash[78:15]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // status[1:0], result_block[9:2], free_count[18:10],
                                  // idle_count[27:19]
  output logic        out_tlast
);
  localparam int IW = rbpl_pkg::IDX_W;
  localparam int CW = rbpl_pkg::CNT_W;
  localparam int BW = $bits(rbpl_pkg::blk_word_t);

  // sequencer states
  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ACHK = 4'd2;
  localparam logic [3:0] S_EV0  = 4'd3;
  localparam logic [3:0] S_EV1  = 4'd4;
  localparam logic [3:0] S_GRD  = 4'd5;
  localparam logic [3:0] S_GWR  = 4'd6;
  localparam logic [3:0] S_BRD  = 4'd7;
  localparam logic [3:0] S_BOP  = 4'd8;
  localparam logic [3:0] S_SCAN = 4'd9;
  localparam logic [3:0] S_MISS = 4'd10;
  localparam logic [3:0] S_HIT  = 4'd11;
  localparam logic [3:0] S_UNL1 = 4'd12;
  localparam logic [3:0] S_UNL2 = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [IW-1:0] init_idx_r, init_idx_nxt;
  // latched request
  logic [1:0] func_r;
  logic [6:0] cnt_r;
  logic [IW-1:0] blk_r;
  logic [rbpl_pkg::HASH_BITS-1:0] hash_r;
  // list heads and counts
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] free_cnt_r, free_cnt_nxt;
  logic [IW:0] lru_first_r, lru_first_nxt, lru_last_r, lru_last_nxt;
  logic [CW-1:0] lru_cnt_r, lru_cnt_nxt;
  // allocate / lookup progress
  logic [6:0] gcnt_r, gcnt_nxt;
  logic [CW-1:0] fin_free_r, fin_free_nxt;
  logic [CW-1:0] sidx_r, sidx_nxt;
  logic pv_r, pv_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  rbpl_pkg::blk_word_t hit_word_r, hit_word_nxt;
  // output register
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  // memory ports
  logic blk_we, blk_re, ring_we, ring_re, prv_we, prv_re, nxt_we, nxt_re;
  logic [IW-1:0] blk_wa, blk_ra, ring_wa, ring_ra, prv_wa, prv_ra, nxt_wa, nxt_ra;
  rbpl_pkg::blk_word_t blk_wd, blk_rd;
  logic [BW-1:0] blk_rd_raw;
  logic [IW-1:0] ring_wd, ring_rd;
  logic [IW:0] prv_wd, prv_rd, nxt_wd, nxt_rd;

  logic out_free, emit, alloc_bad, match;
  logic [1:0] e_status;
  logic [IW-1:0] e_blk;
  logic e_last;
  logic [CW-1:0] e_free;

  assign blk_rd = rbpl_pkg::blk_word_t'(blk_rd_raw);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

  assign alloc_bad = (cnt_r == 7'd0) || (cnt_r > rbpl_pkg::MAX_GRANT) ||
                     (({1'b0, free_cnt_r} + {1'b0, lru_cnt_r}) < {3'b000, cnt_r});
  assign match = pv_r && blk_rd.cached && (blk_rd.hash == hash_r);

  always_comb begin
    state_nxt = state_r;
    init_idx_nxt = init_idx_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt = free_cnt_r;
    lru_first_nxt = lru_first_r;
    lru_last_nxt = lru_last_r;
    lru_cnt_nxt = lru_cnt_r;
    gcnt_nxt = gcnt_r;
    fin_free_nxt = fin_free_r;
    sidx_nxt = sidx_r;
    pv_nxt = 1'b0;
    pidx_nxt = pidx_r;
    hit_idx_nxt = hit_idx_r;
    hit_word_nxt = hit_word_r;
    blk_we = 1'b0; blk_wa = '0; blk_wd = '0; blk_re = 1'b0; blk_ra = blk_r;
    ring_we = 1'b0; ring_wa = '0; ring_wd = '0; ring_re = 1'b0; ring_ra = free_head_r;
    prv_we = 1'b0; prv_wa = '0; prv_wd = rbpl_pkg::LINK_NULL; prv_re = 1'b0; prv_ra = hit_idx_r;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = rbpl_pkg::LINK_NULL; nxt_re = 1'b0; nxt_ra = hit_idx_r;
    emit = 1'b0;
    e_status = rbpl_pkg::ST_OK;
    e_blk = '0;
    e_last = 1'b1;
    e_free = free_cnt_nxt;
    unique case (state_r)
      S_INIT: begin
        // clearing pass: ring gets its index, words and links go empty
        blk_we = 1'b1; blk_wa = init_idx_r;
        ring_we = 1'b1; ring_wa = init_idx_r; ring_wd = init_idx_r;
        prv_we = 1'b1; prv_wa = init_idx_r;
        nxt_we = 1'b1; nxt_wa = init_idx_r;
        init_idx_nxt = init_idx_r + 1'b1;
        if (init_idx_r == IW'(rbpl_pkg::POOL_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            rbpl_pkg::FN_ALLOC:  state_nxt = S_ACHK;
            rbpl_pkg::FN_LOOKUP: begin
              state_nxt = S_SCAN;
              sidx_nxt = '0;
            end
            default: state_nxt = S_BRD;
          endcase
        end
      end
      S_ACHK: begin
        if (alloc_bad) begin
          if (out_free) begin
            emit = 1'b1;
            e_status = rbpl_pkg::ST_EXHAUST;
            state_nxt = S_IDLE;
          end
        end else if ((free_cnt_r < {2'b00, cnt_r}) && !lru_first_r[IW]) begin
          state_nxt = S_EV0;
        end else begin
          gcnt_nxt = '0;
          fin_free_nxt = free_cnt_r - {2'b00, cnt_r};
          state_nxt = S_GRD;
        end
      end
      S_EV0: begin
        // evict lru head to the free tail
        nxt_re = 1'b1; nxt_ra = lru_first_r[IW-1:0];
        blk_we = 1'b1; blk_wa = lru_first_r[IW-1:0];
        if (free_cnt_r != CW'(rbpl_pkg::POOL_BLOCKS)) begin
          ring_we = 1'b1;
          ring_wa = free_head_r + free_cnt_r[IW-1:0];
          ring_wd = lru_first_r[IW-1:0];
          free_cnt_nxt = free_cnt_r + 1'b1;
        end
        lru_cnt_nxt = lru_cnt_r - 1'b1;
        state_nxt = S_EV1;
      end
      S_EV1: begin
        lru_first_nxt = nxt_rd;
        if (nxt_rd[IW]) begin
          lru_last_nxt = rbpl_pkg::LINK_NULL;
        end else begin
          prv_we = 1'b1; prv_wa = nxt_rd[IW-1:0];
        end
        nxt_we = 1'b1; nxt_wa = lru_first_r[IW-1:0];
        state_nxt = S_ACHK;
      end
      S_GRD: begin
        ring_re = 1'b1;
        state_nxt = S_GWR;
      end
      S_GWR: begin
        if (out_free) begin
          blk_we = 1'b1; blk_wa = ring_rd;
          blk_wd.refc = 16'd1;
          free_head_nxt = free_head_r + 1'b1;
          free_cnt_nxt = free_cnt_r - 1'b1;
          emit = 1'b1;
          e_blk = ring_rd;
          e_last = (gcnt_r == cnt_r - 7'd1);
          e_free = fin_free_r;
          gcnt_nxt = gcnt_r + 1'b1;
          state_nxt = e_last ? S_IDLE : S_GRD;
        end
      end
      S_BRD: begin
        blk_re = 1'b1;
        state_nxt = S_BOP;
      end
      S_BOP: begin
        if (out_free) begin
          emit = 1'b1;
          state_nxt = S_IDLE;
          blk_wa = blk_r;
          if (func_r == rbpl_pkg::FN_RELEASE) begin
            if (blk_rd.refc != '0) begin
              blk_we = 1'b1;
              blk_wd = blk_rd;
              blk_wd.refc = blk_rd.refc - 1'b1;
              if (blk_rd.refc == 16'd1) begin
                if (blk_rd.cached) begin
                  // idle cached block joins the lru tail
                  blk_wd.lru = 1'b1;
                  prv_we = 1'b1; prv_wa = blk_r; prv_wd = lru_last_r;
                  if (lru_last_r[IW]) begin
                    lru_first_nxt = {1'b0, blk_r};
                  end else begin
                    nxt_we = 1'b1; nxt_wa = lru_last_r[IW-1:0]; nxt_wd = {1'b0, blk_r};
                  end
                  lru_last_nxt = {1'b0, blk_r};
                  lru_cnt_nxt = lru_cnt_r + 1'b1;
                end else begin
                  blk_wd = '0;
                  if (free_cnt_r != CW'(rbpl_pkg::POOL_BLOCKS)) begin
                    ring_we = 1'b1;
                    ring_wa = free_head_r + free_cnt_r[IW-1:0];
                    ring_wd = blk_r;
                    free_cnt_nxt = free_cnt_r + 1'b1;
                  end
                end
              end
            end
          end else begin
            if (blk_rd.cached) begin
              e_status = rbpl_pkg::ST_PUBL;
            end else if (blk_rd.refc != '0) begin
              blk_we = 1'b1;
              blk_wd = blk_rd;
              blk_wd.cached = 1'b1;
              blk_wd.hash = hash_r;
            end
          end
          e_free = free_cnt_nxt;
        end
      end
      S_SCAN: begin
        // one block word read per cycle, compared in the next cycle
        if (!sidx_r[IW]) begin
          blk_re = 1'b1; blk_ra = sidx_r[IW-1:0];
          sidx_nxt = sidx_r + 1'b1;
          pv_nxt = 1'b1;
          pidx_nxt = sidx_r[IW-1:0];
        end
        if (match) begin
          hit_idx_nxt = pidx_r;
          hit_word_nxt = blk_rd;
          pv_nxt = 1'b0;
          state_nxt = S_HIT;
        end else if (pv_r && (pidx_r == IW'(rbpl_pkg::POOL_BLOCKS - 1))) begin
          pv_nxt = 1'b0;
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        if (out_free) begin
          emit = 1'b1;
          e_status = rbpl_pkg::ST_MISS;
          state_nxt = S_IDLE;
        end
      end
      S_HIT: begin
        if (hit_word_r.lru) begin
          prv_re = 1'b1;
          nxt_re = 1'b1;
          state_nxt = S_UNL1;
        end else if (out_free) begin
          // active block is shared
          blk_we = 1'b1; blk_wa = hit_idx_r; blk_wd = hit_word_r;
          if (hit_word_r.refc != rbpl_pkg::REF_MAX) begin
            blk_wd.refc = hit_word_r.refc + 1'b1;
          end
          emit = 1'b1;
          e_blk = hit_idx_r;
          state_nxt = S_IDLE;
        end
      end
      S_UNL1: begin
        // splice neighbors around the revived block
        if (prv_rd[IW]) begin
          lru_first_nxt = nxt_rd;
        end else begin
          nxt_we = 1'b1; nxt_wa = prv_rd[IW-1:0]; nxt_wd = nxt_rd;
        end
        if (nxt_rd[IW]) begin
          lru_last_nxt = prv_rd;
        end else begin
          prv_we = 1'b1; prv_wa = nxt_rd[IW-1:0]; prv_wd = prv_rd;
        end
        state_nxt = S_UNL2;
      end
      S_UNL2: begin
        if (out_free) begin
          prv_we = 1'b1; prv_wa = hit_idx_r;
          nxt_we = 1'b1; nxt_wa = hit_idx_r;
          blk_we = 1'b1; blk_wa = hit_idx_r; blk_wd = hit_word_r;
          blk_wd.lru = 1'b0;
          blk_wd.refc = 16'd1;
          lru_cnt_nxt = lru_cnt_r - 1'b1;
          emit = 1'b1;
          e_blk = hit_idx_r;
          e_free = free_cnt_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt = out_last_r;
    out_data_nxt = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt = e_last;
      out_data_nxt = {4'b0000, lru_cnt_nxt, e_free, e_blk, e_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_idx_r <= '0;
      free_head_r <= '0;
      free_cnt_r <= CW'(rbpl_pkg::POOL_BLOCKS);
      lru_first_r <= rbpl_pkg::LINK_NULL;
      lru_last_r <= rbpl_pkg::LINK_NULL;
      lru_cnt_r <= '0;
      pv_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_idx_r <= init_idx_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r <= free_cnt_nxt;
      lru_first_r <= lru_first_nxt;
      lru_last_r <= lru_last_nxt;
      lru_cnt_r <= lru_cnt_nxt;
      pv_r <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= in_tuser;
      cnt_r <= in_tdata[6:0];
      blk_r <= in_tdata[14:7];
      hash_r <= in_tdata[78:15];
    end
    gcnt_r <= gcnt_nxt;
    fin_free_r <= fin_free_nxt;
    sidx_r <= sidx_nxt;
    pidx_r <= pidx_nxt;
    hit_idx_r <= hit_idx_nxt;
    hit_word_r <= hit_word_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  rbpl_ram #(.WIDTH(BW), .DEPTH(rbpl_pkg::POOL_BLOCKS)) u_blk_ram (
    .clk(clk), .wr_en(blk_we), .wr_addr(blk_wa), .wr_data(blk_wd),
    .rd_en(blk_re), .rd_addr(blk_ra), .rd_data(blk_rd_raw)
  );
  rbpl_ram #(.WIDTH(IW), .DEPTH(rbpl_pkg::POOL_BLOCKS)) u_ring_ram (
    .clk(clk), .wr_en(ring_we), .wr_addr(ring_wa), .wr_data(ring_wd),
    .rd_en(ring_re), .rd_addr(ring_ra), .rd_data(ring_rd)
  );
  rbpl_ram #(.WIDTH(IW + 1), .DEPTH(rbpl_pkg::POOL_BLOCKS)) u_prev_ram (
    .clk(clk), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
    .rd_en(prv_re), .rd_addr(prv_ra), .rd_data(prv_rd)
  );
  rbpl_ram #(.WIDTH(IW + 1), .DEPTH(rbpl_pkg::POOL_BLOCKS)) u_next_ram (
    .clk(clk), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
    .rd_en(nxt_re), .rd_addr(nxt_ra), .rd_data(nxt_rd)
  );

  // free and idle blocks never exceed the pool
  `RBPL_ASSERT_IMP(a_pool_bound, clk, rst_n, 1'b1,
    ({1'b0, free_cnt_r} + {1'b0, lru_cnt_r}) <= 10'(rbpl_pkg::POOL_BLOCKS))
  // between requests an empty lru list has a null head and zero count together
  `RBPL_ASSERT_IMP(a_lru_empty, clk, rst_n, state_r == S_IDLE,
    lru_first_r[IW] == (lru_cnt_r == '0))
  // a grant only pops a nonempty free ring
  `RBPL_ASSERT_IMP(a_grant_nonempty, clk, rst_n, state_r == S_GWR, free_cnt_r != '0)
  // a revived block must come out of the lru list
  `RBPL_ASSERT_NEXT(a_unlink_count, clk, rst_n,
    (state_r == S_UNL2) && out_free, lru_cnt_r == $past(lru_cnt_r) - 1'b1)
endmodule
